>>> hdl/least_prime_factor_sieve_assert.svh
// Assertion helpers used by the sieve RTL.
`ifndef LEAST_PRIME_FACTOR_SIEVE_ASSERT_SVH
`define LEAST_PRIME_FACTOR_SIEVE_ASSERT_SVH

// Condition must hold at every clock edge outside reset.
`define LPFS_ASSERT_ALWAYS(label, ck, rs, cond, msg) \
  label: assert property (@(posedge ck) disable iff (rs) (cond)) else $error(msg);

// Consequent must hold in the same cycle as the antecedent.
`define LPFS_ASSERT_IMPLY(label, ck, rs, ante, cons, msg) \
  label: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define LPFS_ASSERT_NEXT(label, ck, rs, ante, cons, msg) \
  label: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) else $error(msg);

`endif

>>> hdl/lpfs_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package lpfs_pkg;

  // Field widths
  localparam int LIMIT_W = 18;
  localparam int FUNC_W  = 2;
  localparam int INDEX_W = 17;
  localparam int VALUE_W = 17;
  localparam int COUNT_W = 15;

  // Default capacities
  localparam int DEF_MAX_LIMIT  = 131072;
  localparam int DEF_MAX_PRIMES = 16384;

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(131072);

  // Item selectors
  localparam logic [FUNC_W-1:0] FUNC_BUILD = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_LPF   = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_KTH   = 2'd2;

  typedef struct packed {
    logic [VALUE_W-1:0] value;
    logic               is_prime;
    logic [COUNT_W-1:0] prime_count;
    logic               ok;
  } lpfs_result_t;

endpackage

`default_nettype wire

>>> hdl/lpfs_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface lpfs_req_if import lpfs_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [FUNC_W-1:0]  func;
  logic [INDEX_W-1:0] index;

  modport source (output valid, output func, output index, input ready);
  modport sink (input valid, input func, input index, output ready);
endinterface

interface lpfs_rsp_if import lpfs_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [VALUE_W-1:0] value;
  logic               is_prime;
  logic [COUNT_W-1:0] prime_count;
  logic               ok;

  modport source (output valid, output value, output is_prime, output prime_count,
                  output ok, input ready);
  modport sink (input valid, input value, input is_prime, input prime_count,
                input ok, output ready);
endinterface

`default_nettype wire

>>> hdl/lpfs_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module lpfs_ram #(
  parameter int WIDTH = 17,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

>>> hdl/lpfs_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
`include "least_prime_factor_sieve_assert.svh"

module lpfs_ctrl import lpfs_pkg::*; #(
  parameter int MAX_LIMIT  = DEF_MAX_LIMIT,
  parameter int MAX_PRIMES = DEF_MAX_PRIMES
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic [LIMIT_W-1:0] limit,
  lpfs_req_if.sink                req,
  output logic                    res_valid,
  input  wire logic               res_ready,
  output lpfs_result_t            res
);

  localparam int AW = $clog2(MAX_LIMIT);
  localparam int NW = $clog2(MAX_LIMIT + 1);
  localparam int PW = $clog2(MAX_PRIMES);
  localparam int CW = $clog2(MAX_PRIMES + 1);
  localparam int MW = AW + NW;
  localparam int XW = (LIMIT_W > NW) ? LIMIT_W : NW;
  localparam int QW = (INDEX_W > NW) ? INDEX_W : NW;
  localparam int KW = (INDEX_W > CW) ? INDEX_W : CW;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_CLEAR = 3'd1;
  localparam logic [2:0] S_LOAD  = 3'd2;
  localparam logic [2:0] S_TEST  = 3'd3;
  localparam logic [2:0] S_FETCH = 3'd4;
  localparam logic [2:0] S_MUL   = 3'd5;
  localparam logic [2:0] S_MARK  = 3'd6;
  localparam logic [2:0] S_REPLY = 3'd7;

  logic [2:0]         state;
  logic [NW-1:0]      n_reg;
  logic [NW-1:0]      span;
  logic [CW-1:0]      pf;
  logic               built;
  logic [NW-1:0]      c;
  logic [NW-1:0]      i;
  logic [CW-1:0]      j;
  logic [AW-1:0]      lpf;
  logic [AW-1:0]      pj;
  logic [MW-1:0]      prod;
  logic [FUNC_W-1:0]  q_func;
  logic [INDEX_W-1:0] q_idx;

  logic               req_fire;
  logic [NW-1:0]      n_eff;
  logic               list_full;
  logic               is_new_prime;
  logic               prod_out;

  logic               ft_we;
  logic [AW-1:0]      ft_waddr;
  logic [AW-1:0]      ft_wdata;
  logic               ft_re;
  logic [AW-1:0]      ft_raddr;
  logic [AW-1:0]      ft_rdata;
  logic               pl_we;
  logic [PW-1:0]      pl_waddr;
  logic [AW-1:0]      pl_wdata;
  logic               pl_re;
  logic [PW-1:0]      pl_raddr;
  logic [AW-1:0]      pl_rdata;

  assign req.ready    = (state == S_IDLE);
  assign req_fire     = req.valid && req.ready;
  assign res_valid    = (state == S_REPLY);
  assign n_eff        = (XW'(limit) > XW'(MAX_LIMIT)) ? NW'(MAX_LIMIT) : NW'(limit);
  assign list_full    = (pf >= CW'(MAX_PRIMES));
  assign is_new_prime = (ft_rdata == '0);
  assign prod_out     = (prod >= MW'(n_reg));

  // Least prime factor table and prime list
  lpfs_ram #(.WIDTH(AW), .DEPTH(MAX_LIMIT)) u_factor_ram (
    .clk   (clk),
    .we    (ft_we),
    .waddr (ft_waddr),
    .wdata (ft_wdata),
    .re    (ft_re),
    .raddr (ft_raddr),
    .rdata (ft_rdata)
  );

  lpfs_ram #(.WIDTH(AW), .DEPTH(MAX_PRIMES)) u_prime_ram (
    .clk   (clk),
    .we    (pl_we),
    .waddr (pl_waddr),
    .wdata (pl_wdata),
    .re    (pl_re),
    .raddr (pl_raddr),
    .rdata (pl_rdata)
  );

  // Steer memory ports by state
  always_comb begin
    ft_we    = 1'b0;
    ft_waddr = '0;
    ft_wdata = '0;
    ft_re    = 1'b0;
    ft_raddr = AW'(req.index);
    pl_we    = 1'b0;
    pl_waddr = pf[PW-1:0];
    pl_wdata = i[AW-1:0];
    pl_re    = 1'b0;
    pl_raddr = PW'(req.index);
    unique case (state)
      S_IDLE: begin
        ft_re = req_fire && (req.func == FUNC_LPF);
        pl_re = req_fire && (req.func == FUNC_KTH);
      end
      S_CLEAR: begin
        ft_we    = (c < n_reg);
        ft_waddr = c[AW-1:0];
        ft_wdata = (c == NW'(1)) ? AW'(1) : '0;
      end
      S_LOAD: begin
        ft_re    = (i < n_reg);
        ft_raddr = i[AW-1:0];
      end
      S_TEST: begin
        ft_we    = is_new_prime && !list_full;
        ft_waddr = i[AW-1:0];
        ft_wdata = i[AW-1:0];
        pl_we    = is_new_prime && !list_full;
      end
      S_FETCH: begin
        pl_re    = (j < pf);
        pl_raddr = j[PW-1:0];
      end
      S_MARK: begin
        ft_we    = !prod_out;
        ft_waddr = prod[AW-1:0];
        ft_wdata = pj;
      end
      default: begin
      end
    endcase
  end

  // Sequencer: clear sweep, then the linear sieve over i with the inner prime walk
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      n_reg <= '0;
      span  <= '0;
      pf    <= '0;
      built <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (req_fire) begin
            q_func <= req.func;
            q_idx  <= req.index;
            if (req.func == FUNC_BUILD) begin
              n_reg <= n_eff;
              span  <= n_eff;
              pf    <= '0;
              c     <= '0;
              state <= S_CLEAR;
            end else begin
              state <= S_REPLY;
            end
          end
        end
        S_CLEAR: begin
          if (c < n_reg) begin
            c <= c + NW'(1);
          end else begin
            i     <= NW'(2);
            state <= S_LOAD;
          end
        end
        S_LOAD: begin
          if (i < n_reg) begin
            state <= S_TEST;
          end else begin
            built <= 1'b1;
            state <= S_REPLY;
          end
        end
        S_TEST: begin
          j <= '0;
          if (is_new_prime) begin
            if (list_full) begin
              // Stop here so no index past the last listed prime is exposed
              span  <= i;
              built <= 1'b1;
              state <= S_REPLY;
            end else begin
              pf    <= pf + CW'(1);
              lpf   <= i[AW-1:0];
              state <= S_FETCH;
            end
          end else begin
            lpf   <= ft_rdata;
            state <= S_FETCH;
          end
        end
        S_FETCH: begin
          if (j < pf) begin
            state <= S_MUL;
          end else begin
            i     <= i + NW'(1);
            state <= S_LOAD;
          end
        end
        S_MUL: begin
          if (pl_rdata > lpf) begin
            i     <= i + NW'(1);
            state <= S_LOAD;
          end else begin
            pj    <= pl_rdata;
            prod  <= MW'(pl_rdata) * MW'(i);
            state <= S_MARK;
          end
        end
        S_MARK: begin
          if (prod_out) begin
            i     <= i + NW'(1);
            state <= S_LOAD;
          end else begin
            j     <= j + CW'(1);
            state <= S_FETCH;
          end
        end
        S_REPLY: begin
          if (res_ready) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Form the result from the held read data
  always_comb begin
    res             = '0;
    res.prime_count = COUNT_W'(pf);
    case (q_func)
      FUNC_BUILD: begin
        res.ok = 1'b1;
      end
      FUNC_LPF: begin
        if (built && (QW'(q_idx) < QW'(span))) begin
          res.value    = VALUE_W'(ft_rdata);
          res.is_prime = (q_idx >= INDEX_W'(2)) && (QW'(ft_rdata) == QW'(q_idx));
          res.ok       = 1'b1;
        end
      end
      FUNC_KTH: begin
        if (built && (KW'(q_idx) < KW'(pf))) begin
          res.value    = VALUE_W'(pl_rdata);
          res.is_prime = 1'b1;
          res.ok       = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  `LPFS_ASSERT_ALWAYS(a_pf_cap, clk, rst, pf <= CW'(MAX_PRIMES), "prime count over capacity")
  `LPFS_ASSERT_ALWAYS(a_span_cap, clk, rst, span <= n_reg, "span beyond build range")
  `LPFS_ASSERT_IMPLY(a_lpf_valid, clk, rst, state == S_MUL, lpf >= AW'(2), "bad factor in walk")
  `LPFS_ASSERT_NEXT(a_reply_idle, clk, rst, res_valid && res_ready, state == S_IDLE, "stuck reply")

endmodule

`default_nettype wire

>>> hdl/least_prime_factor_sieve.sv
`timescale 1ns / 1ps
`default_nettype none

// Least-prime-factor sieve. A build item (func 0) clears the factor table over
// n = min(limit, MAX_LIMIT) entries, one entry a cycle, and then runs the linear
// sieve with one shared multiply and compare unit under a small sequencer: each
// index passes the load and test states, and its prime walk steps through fetch,
// multiply and mark for each composite marked; no item is taken during a build.
// Queries (func 1: least prime factor and prime flag; func 2: k-th prime, k from
// 0) read the registered table and then hand the result to the output register,
// which lets the next item in while it waits. Every result carries the prime
// count of the last build; a query before any build or out of range returns ok
// low. A new limit takes effect at the next build.
module least_prime_factor_sieve import lpfs_pkg::*; #(
  parameter int MAX_LIMIT  = DEF_MAX_LIMIT,
  parameter int MAX_PRIMES = DEF_MAX_PRIMES
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               cfg_we,
  input  wire logic [LIMIT_W-1:0] cfg_data,
  lpfs_req_if.sink                req,
  lpfs_rsp_if.source              rsp
);

  logic [LIMIT_W-1:0] limit;
  logic               res_valid;
  logic               res_ready;
  lpfs_result_t       res;
  logic               out_valid;
  lpfs_result_t       out_res;

  // Hold the limit register
  always_ff @(posedge clk) begin
    if (rst) begin
      limit <= LIMIT_RESET;
    end else if (cfg_we) begin
      limit <= cfg_data;
    end
  end

  lpfs_ctrl #(
    .MAX_LIMIT  (MAX_LIMIT),
    .MAX_PRIMES (MAX_PRIMES)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .limit     (limit),
    .req       (req),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  // Output register: load when empty or when the current result transfers
  assign res_ready = !out_valid || rsp.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_ready) begin
      out_valid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      out_res <= res;
    end
  end

  assign rsp.valid       = out_valid;
  assign rsp.value       = out_res.value;
  assign rsp.is_prime    = out_res.is_prime;
  assign rsp.prime_count = out_res.prime_count;
  assign rsp.ok          = out_res.ok;

endmodule

`default_nettype wire

>>> verif/tb_least_prime_factor_sieve.sv
`timescale 1ns / 1ps

module tb_least_prime_factor_sieve;
  import lpfs_pkg::*;

  // Selector that the block answers with ok low and no state change
  localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;
  localparam logic [INDEX_W-1:0] INDEX_MAX = '1;
  localparam logic [LIMIT_W-1:0] LIMIT_ALL_ONES = '1;

  // A full-size build passes with no transfer on either side
  localparam int STALL_LIMIT = 4000000;
  localparam int DRAIN_CYCLES = 32;
  localparam int RANDOM_ITEMS = 1600;

  // Least-prime-factor tables kept alongside the block, plus the results owed
  class sieve_scoreboard;
    logic [VALUE_W-1:0] lpf_tab [DEF_MAX_LIMIT];
    logic [VALUE_W-1:0] prime_tab [DEF_MAX_PRIMES];
    int unsigned found;
    int unsigned span;
    bit built;
    logic [LIMIT_W-1:0] limit_val;
    lpfs_result_t due_q [$];
    int errors;

    function new();
      found = 0;
      span = 0;
      built = 0;
      limit_val = LIMIT_RESET;
      errors = 0;
    endfunction

    function void set_limit(logic [LIMIT_W-1:0] v);
      limit_val = v;
    endfunction

    function int pending();
      return due_q.size();
    endfunction

    // Linear sieve: each composite is marked once, by its least prime factor
    function void rebuild_tables();
      int unsigned n;
      int unsigned i;
      int unsigned j;
      int unsigned p;
      int unsigned lpf;
      longint unsigned prod;
      n = 32'(limit_val);
      if (n > DEF_MAX_LIMIT) n = DEF_MAX_LIMIT;
      found = 0;
      span = n;
      for (i = 0; i < n; i++) lpf_tab[i] = '0;
      if (n > 1) lpf_tab[1] = VALUE_W'(1);
      for (i = 2; i < n; i++) begin
        lpf = 32'(lpf_tab[i]);
        if (lpf == 0) begin
          // stop short when the prime list is full
          if (found >= DEF_MAX_PRIMES) begin
            span = i;
            break;
          end
          lpf_tab[i] = VALUE_W'(i);
          prime_tab[found] = VALUE_W'(i);
          found++;
          lpf = i;
        end
        for (j = 0; j < found; j++) begin
          p = 32'(prime_tab[j]);
          prod = longint'(p) * longint'(i);
          if (p > lpf || prod >= n) break;
          lpf_tab[prod] = VALUE_W'(p);
        end
      end
      built = 1;
    endfunction

    // Work out the result owed for one accepted request
    function void note_request(logic [FUNC_W-1:0] f, logic [INDEX_W-1:0] idx);
      lpfs_result_t res;
      res = '0;
      case (f)
        FUNC_BUILD: begin
          rebuild_tables();
          res.ok = 1'b1;
        end
        FUNC_LPF: begin
          if (built && idx < span) begin
            res.value = lpf_tab[idx];
            res.is_prime = (idx >= 2 && lpf_tab[idx] == idx);
            res.ok = 1'b1;
          end
        end
        FUNC_KTH: begin
          if (built && idx < found) begin
            res.value = prime_tab[idx];
            res.is_prime = 1'b1;
            res.ok = 1'b1;
          end
        end
        default: ;
      endcase
      res.prime_count = COUNT_W'(found);
      due_q = {due_q, res};
    endfunction

    task report(string msg);
      errors++;
      $display("%0t ns: %s", $time, msg);
    endtask

    // Compare one result transfer with the oldest owed result
    task check_result(lpfs_result_t got);
      lpfs_result_t exp;
      if (due_q.size() == 0) begin
        report($sformatf("unexpected result: value %0d prime %0b count %0d ok %0b",
                         got.value, got.is_prime, got.prime_count, got.ok));
        return;
      end
      exp = due_q.pop_front();
      if (got.value !== exp.value)
        report($sformatf("value: got %0d expected %0d", got.value, exp.value));
      if (got.is_prime !== exp.is_prime)
        report($sformatf("is_prime: got %0b expected %0b", got.is_prime, exp.is_prime));
      if (got.prime_count !== exp.prime_count)
        report($sformatf("prime_count: got %0d expected %0d", got.prime_count,
                         exp.prime_count));
      if (got.ok !== exp.ok)
        report($sformatf("ok: got %0b expected %0b", got.ok, exp.ok));
    endtask
  endclass

  logic clk;
  logic rst;
  logic cfg_we;
  logic [LIMIT_W-1:0] cfg_data;

  lpfs_req_if req_bus ();
  lpfs_rsp_if rsp_bus ();

  sieve_scoreboard sb;

  int burst_left;
  int rdy_hold;
  logic rdy_level;
  int idle_cycles;
  int queries_sent;
  bit big_limit_armed;

  least_prime_factor_sieve uut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .req      (req_bus.sink),
    .rsp      (rsp_bus.source)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Present one request, starting a new burst after a random gap when due
  task automatic send_item(input logic [FUNC_W-1:0] f, input logic [INDEX_W-1:0] idx);
    int gap;
    int r;
    @(negedge clk);
    if (burst_left == 0) begin
      r = $urandom_range(0, 9);
      if (r < 2) begin
        gap = 0;
        burst_left = $urandom_range(40, 120);
      end else if (r == 2) begin
        gap = $urandom_range(10, 25);
        burst_left = $urandom_range(1, 6);
      end else begin
        gap = $urandom_range(1, 5);
        burst_left = $urandom_range(1, 10);
      end
      if (gap > 0) begin
        req_bus.valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    req_bus.valid <= 1'b1;
    req_bus.func <= f;
    req_bus.index <= idx;
    do @(posedge clk); while (!req_bus.ready);
    sb.note_request(f, idx);
    if (f != FUNC_UNUSED) queries_sent++;
  endtask

  // Drop valid and hold until every owed result has come back
  task automatic wait_idle();
    @(negedge clk);
    req_bus.valid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_limit(input logic [LIMIT_W-1:0] v);
    wait_idle();
    cfg_we <= 1'b1;
    cfg_data <= v;
    @(negedge clk);
    cfg_we <= 1'b0;
    sb.set_limit(v);
  endtask

  // Mostly small limits so builds stay short; a few mid-sized and degenerate ones
  function automatic logic [LIMIT_W-1:0] pick_limit();
    int r;
    r = $urandom_range(0, 19);
    if (r == 0) return LIMIT_W'($urandom_range(0, 3));
    if (r == 1) return LIMIT_W'($urandom_range(1000, 6000));
    return LIMIT_W'($urandom_range(2, 400));
  endfunction

  // Mostly in range, some at the edge, some anywhere in the field
  function automatic logic [INDEX_W-1:0] pick_index(input int unsigned bound);
    int r;
    int unsigned v;
    r = $urandom_range(0, 19);
    if (r < 3 || bound == 0) return INDEX_W'($urandom());
    if (r < 6) begin
      v = bound + $urandom_range(0, 2) - 1;
      if (v > INDEX_MAX) v = INDEX_MAX;
      return INDEX_W'(v);
    end
    return INDEX_W'($urandom_range(0, bound - 1));
  endfunction

  task automatic send_query();
    int r;
    r = $urandom_range(0, 24);
    if (r == 0)
      send_item(FUNC_UNUSED, INDEX_W'($urandom()));
    else if (r < 13)
      send_item(FUNC_LPF, pick_index(sb.span));
    else
      send_item(FUNC_KTH, pick_index(sb.found));
  endtask

  // Receiver: segments of ready high or low, with long stall-free stretches
  always @(negedge clk) begin
    if (rdy_hold == 0) begin
      rdy_level = ~rdy_level;
      if (rdy_level)
        rdy_hold = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 200)
                                               : $urandom_range(1, 8);
      else
        rdy_hold = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 30)
                                               : $urandom_range(1, 4);
    end
    rdy_hold--;
    rsp_bus.ready <= rdy_level;
  end

  // Check each result transfer
  always @(posedge clk) begin
    lpfs_result_t got;
    if (!rst && rsp_bus.valid && rsp_bus.ready) begin
      got.value = rsp_bus.value;
      got.is_prime = rsp_bus.is_prime;
      got.prime_count = rsp_bus.prime_count;
      got.ok = rsp_bus.ok;
      sb.check_result(got);
    end
  end

  // Watchdog on cycles with no transfer on either side
  always @(posedge clk) begin
    if (rst) begin
      idle_cycles <= 0;
    end else if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int n;
    int choice;
    sb = new();
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_data = '0;
    req_bus.valid = 1'b0;
    req_bus.func = FUNC_BUILD;
    req_bus.index = '0;
    rsp_bus.ready = 1'b0;
    rdy_level = 1'b0;
    rdy_hold = 0;
    burst_left = 0;
    queries_sent = 0;
    big_limit_armed = 0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Queries before any build, and the unused selector
    send_item(FUNC_LPF, '0);
    send_item(FUNC_KTH, '0);
    send_item(FUNC_UNUSED, INDEX_MAX);

    // Smallest legal limit: only indices 0 and 1, no primes
    write_limit(LIMIT_W'(2));
    send_item(FUNC_BUILD, '0);
    send_item(FUNC_LPF, INDEX_W'(0));
    send_item(FUNC_LPF, INDEX_W'(1));
    send_item(FUNC_KTH, INDEX_W'(0));

    // Limits below two
    write_limit(LIMIT_W'(0));
    send_item(FUNC_BUILD, INDEX_MAX);
    send_item(FUNC_LPF, INDEX_W'(0));
    write_limit(LIMIT_W'(1));
    send_item(FUNC_BUILD, '0);
    send_item(FUNC_LPF, INDEX_W'(0));

    // Small table, then a new limit written without a rebuild
    write_limit(LIMIT_W'(30));
    send_item(FUNC_BUILD, '0);
    send_item(FUNC_LPF, INDEX_W'(29));
    send_item(FUNC_LPF, INDEX_W'(25));
    send_item(FUNC_KTH, INDEX_W'(9));
    send_item(FUNC_KTH, INDEX_W'(10));
    write_limit(LIMIT_W'(DEF_MAX_LIMIT));
    send_item(FUNC_LPF, INDEX_W'(29));
    send_item(FUNC_LPF, INDEX_W'(30));

    // Limit above capacity: one full-size build
    write_limit(LIMIT_ALL_ONES);
    send_item(FUNC_BUILD, '0);
    send_item(FUNC_LPF, INDEX_MAX);
    send_item(FUNC_LPF, INDEX_MAX - 1);
    send_item(FUNC_KTH, INDEX_W'(sb.found - 1));
    send_item(FUNC_KTH, INDEX_W'(sb.found));

    // Random queries against the full-size tables
    queries_sent = 0;
    repeat (250) send_query();

    // Random phases: new limit and build, rebuilds, stray limit writes, queries
    while (queries_sent < RANDOM_ITEMS) begin
      choice = $urandom_range(0, 9);
      if (choice <= 5 || (choice == 6 && big_limit_armed)) begin
        write_limit(pick_limit());
        big_limit_armed = 0;
        send_item(FUNC_BUILD, INDEX_W'($urandom()));
      end else if (choice == 6) begin
        send_item(FUNC_BUILD, INDEX_W'($urandom()));
      end else if (choice == 7) begin
        write_limit(LIMIT_W'($urandom()));
        big_limit_armed = 1;
      end
      n = $urandom_range(8, 60);
      repeat (n) send_query();
    end

    // Drain, then allow for any stray result
    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
